// ===== sv/ymb_pkg.sv =====
// shared constants, result types and the crc helper for the ymodem block receiver
package ymb_pkg;

   localparam int YMB_SIZE_BITS  = 32;
   localparam int YMB_FIFO_DEPTH = 4;
   localparam int YMB_IDX_BITS   = 11;

   localparam logic [YMB_IDX_BITS-1:0] YMB_SHORT_LEN = 11'd128;
   localparam logic [YMB_IDX_BITS-1:0] YMB_LONG_LEN  = 11'd1024;

   localparam logic [15:0] YMB_CRC_POLY = 16'h1021;

   // link characters
   localparam logic [7:0] YMB_SOH  = 8'h01;
   localparam logic [7:0] YMB_STX  = 8'h02;
   localparam logic [7:0] YMB_EOT  = 8'h04;
   localparam logic [7:0] YMB_ACK  = 8'h06;
   localparam logic [7:0] YMB_NAK  = 8'h15;
   localparam logic [7:0] YMB_REQ  = 8'h43;
   localparam logic [7:0] YMB_OVER = 8'h4F;
   localparam logic [7:0] YMB_HDR_NUM     = 8'h00;
   localparam logic [7:0] YMB_HDR_NUM_INV = 8'hFF;

   // item kinds
   localparam logic YMB_KIND_BYTE = 1'b0;
   localparam logic YMB_KIND_TICK = 1'b1;

   // block end codes
   localparam logic [1:0] YMB_END_NONE      = 2'd0;
   localparam logic [1:0] YMB_END_COMMIT    = 2'd1;
   localparam logic [1:0] YMB_END_DISCARD   = 2'd2;

   // status codes
   localparam logic [1:0] YMB_STAT_RUN      = 2'd0;
   localparam logic [1:0] YMB_STAT_FINISHED = 2'd1;
   localparam logic [1:0] YMB_STAT_ABORTED  = 2'd2;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic [1:0] block_end;
      logic [1:0] status;
      logic       last;
   } ymb_result_type;

   typedef struct packed {
      logic [1:0]     count;
      ymb_result_type first;
      ymb_result_type second;
   } ymb_step_type;

   function automatic ymb_result_type ymb_make_result(
      input logic       tx_valid,
      input logic [7:0] tx_byte,
      input logic       data_valid,
      input logic [7:0] data_byte,
      input logic [1:0] block_end,
      input logic [1:0] status
   );
      ymb_result_type r;
      r.tx_valid   = tx_valid;
      r.tx_byte    = tx_byte;
      r.data_valid = data_valid;
      r.data_byte  = data_byte;
      r.block_end  = block_end;
      r.status     = status;
      r.last       = 1'b0;
      return r;
   endfunction

   // crc-16/xmodem, one byte msb first
   function automatic logic [15:0] ymb_crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ YMB_CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/ymb_core.sv =====
// protocol state and per-item reply logic of the ymodem block receiver
module ymb_core
   import ymb_pkg::*;
#(
   parameter int SIZE_BITS = YMB_SIZE_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_valid,
   input  logic         step_kind,
   input  logic [7:0]   step_byte,
   output ymb_step_type step_out
);

   typedef enum logic [2:0] {
      PH_WAIT, PH_DATA, PH_FINAL, PH_DONE, PH_ABORT
   } phase_type;

   typedef enum logic [2:0] {
      SS_START, SS_NUM, SS_NUM_INV, SS_PAYLOAD, SS_CRC_HI, SS_CRC_LO
   } sub_type;

   phase_type               phase_ff, phase_in;
   sub_type                 sub_ff, sub_in;
   logic                    long_block_ff, long_block_in;
   logic [YMB_IDX_BITS-1:0] byte_index_ff, byte_index_in;
   logic [15:0]             crc_ff, crc_in;
   logic [7:0]              crc_high_ff, crc_high_in;
   logic [1:0]              eot_count_ff, eot_count_in;
   logic [SIZE_BITS-1:0]    remaining_ff, remaining_in;
   logic                    name_done_ff, name_done_in;
   logic                    digits_ff, digits_in;
   logic [SIZE_BITS-1:0]    accum_ff, accum_in;

   logic [YMB_IDX_BITS-1:0] len;
   logic [SIZE_BITS-1:0]    len_ext;
   logic [YMB_IDX_BITS-1:0] index_next;
   logic [15:0]             crc_next;
   logic [SIZE_BITS+3:0]    accum_wide;
   logic [SIZE_BITS-1:0]    accum_sat;
   logic                    is_digit;
   logic                    crc_ok;
   logic                    in_size;
   logic [SIZE_BITS-1:0]    commit_take;
   logic [1:0]              eot_next;

   assign len        = long_block_ff ? YMB_LONG_LEN : YMB_SHORT_LEN;
   assign len_ext    = {{(SIZE_BITS-YMB_IDX_BITS){1'b0}}, len};
   assign index_next = byte_index_ff + 1'b1;
   assign crc_next   = ymb_crc_update(crc_ff, step_byte);
   assign is_digit   = (step_byte >= 8'h30) && (step_byte <= 8'h39);
   // times ten as two shifts, plus the digit value
   assign accum_wide = ({4'b0000, accum_ff} << 3) + ({4'b0000, accum_ff} << 1)
                       + {{SIZE_BITS{1'b0}}, step_byte[3:0]};
   assign accum_sat  = (accum_wide[SIZE_BITS+3:SIZE_BITS] != 4'd0) ? '1
                                                                    : accum_wide[SIZE_BITS-1:0];
   assign crc_ok     = ({crc_high_ff, step_byte} == crc_ff);
   assign in_size    = ({{(SIZE_BITS-YMB_IDX_BITS){1'b0}}, byte_index_ff} < remaining_ff);
   assign commit_take = (remaining_ff < len_ext) ? remaining_ff : len_ext;
   assign eot_next   = eot_count_ff + 2'd1;

   always_comb begin
      phase_in      = phase_ff;
      sub_in        = sub_ff;
      long_block_in = long_block_ff;
      byte_index_in = byte_index_ff;
      crc_in        = crc_ff;
      crc_high_in   = crc_high_ff;
      eot_count_in  = eot_count_ff;
      remaining_in  = remaining_ff;
      name_done_in  = name_done_ff;
      digits_in     = digits_ff;
      accum_in      = accum_ff;
      step_out      = '0;

      if (step_valid && (phase_ff == PH_WAIT || phase_ff == PH_DATA || phase_ff == PH_FINAL)) begin
         if (step_kind == YMB_KIND_TICK) begin
            if (phase_ff == PH_WAIT && sub_ff == SS_START) begin
               step_out.first = ymb_make_result(1'b1, YMB_REQ, 1'b0, 8'h00,
                                                YMB_END_NONE, YMB_STAT_RUN);
               step_out.count = 2'd1;
            end
         end else begin
            case (sub_ff)
               SS_START: begin
                  if (phase_ff == PH_DATA && step_byte == YMB_EOT) begin
                     eot_count_in = eot_next;
                     if (eot_next >= 2'd2) begin
                        phase_in = PH_FINAL;
                        step_out.first  = ymb_make_result(1'b1, YMB_ACK, 1'b0, 8'h00,
                                                          YMB_END_NONE, YMB_STAT_RUN);
                        step_out.second = ymb_make_result(1'b1, YMB_REQ, 1'b0, 8'h00,
                                                          YMB_END_NONE, YMB_STAT_RUN);
                        step_out.count  = 2'd2;
                     end else begin
                        step_out.first = ymb_make_result(1'b1, YMB_NAK, 1'b0, 8'h00,
                                                         YMB_END_NONE, YMB_STAT_RUN);
                        step_out.count = 2'd1;
                     end
                  end else if (step_byte == YMB_SOH || step_byte == YMB_STX) begin
                     long_block_in = (step_byte == YMB_STX);
                     sub_in        = SS_NUM;
                     byte_index_in = '0;
                     crc_in        = '0;
                     if (phase_ff == PH_WAIT) begin
                        name_done_in = 1'b0;
                        digits_in    = 1'b0;
                        accum_in     = '0;
                     end
                  end
               end
               SS_NUM, SS_NUM_INV: begin
                  if (phase_ff == PH_WAIT &&
                      step_byte != ((sub_ff == SS_NUM) ? YMB_HDR_NUM : YMB_HDR_NUM_INV)) begin
                     phase_in = PH_ABORT;
                     sub_in   = SS_START;
                     step_out.first = ymb_make_result(1'b0, 8'h00, 1'b0, 8'h00,
                                                      YMB_END_NONE, YMB_STAT_ABORTED);
                     step_out.count = 2'd1;
                  end else begin
                     sub_in = (sub_ff == SS_NUM) ? SS_NUM_INV : SS_PAYLOAD;
                  end
               end
               SS_PAYLOAD: begin
                  crc_in = crc_next;
                  if (phase_ff == PH_WAIT) begin
                     // header block: file name, nul, then decimal size
                     if (!name_done_ff) begin
                        if (step_byte == 8'h00) begin
                           name_done_in = 1'b1;
                           digits_in    = 1'b1;
                        end
                     end else if (digits_ff) begin
                        if (is_digit) begin
                           accum_in = accum_sat;
                        end else begin
                           digits_in = 1'b0;
                        end
                     end
                  end else if (phase_ff == PH_DATA && in_size) begin
                     step_out.first = ymb_make_result(1'b0, 8'h00, 1'b1, step_byte,
                                                      YMB_END_NONE, YMB_STAT_RUN);
                     step_out.count = 2'd1;
                  end
                  byte_index_in = index_next;
                  if (index_next >= len) begin
                     sub_in = SS_CRC_HI;
                  end
               end
               SS_CRC_HI: begin
                  crc_high_in = step_byte;
                  sub_in      = SS_CRC_LO;
               end
               default: begin
                  sub_in = SS_START;
                  if (phase_ff == PH_FINAL) begin
                     phase_in = PH_DONE;
                     step_out.first  = ymb_make_result(1'b1, YMB_ACK, 1'b0, 8'h00,
                                                       YMB_END_NONE, YMB_STAT_RUN);
                     step_out.second = ymb_make_result(1'b1, YMB_OVER, 1'b0, 8'h00,
                                                       YMB_END_NONE, YMB_STAT_FINISHED);
                     step_out.count  = 2'd2;
                  end else if (phase_ff == PH_WAIT) begin
                     if (crc_ok) begin
                        remaining_in = name_done_ff ? accum_ff : '0;
                        phase_in     = PH_DATA;
                        step_out.first  = ymb_make_result(1'b1, YMB_ACK, 1'b0, 8'h00,
                                                          YMB_END_NONE, YMB_STAT_RUN);
                        step_out.second = ymb_make_result(1'b1, YMB_REQ, 1'b0, 8'h00,
                                                          YMB_END_NONE, YMB_STAT_RUN);
                        step_out.count  = 2'd2;
                     end else begin
                        step_out.first = ymb_make_result(1'b1, YMB_NAK, 1'b0, 8'h00,
                                                         YMB_END_NONE, YMB_STAT_RUN);
                        step_out.count = 2'd1;
                     end
                  end else if (crc_ok) begin
                     remaining_in   = remaining_ff - commit_take;
                     step_out.first = ymb_make_result(1'b1, YMB_ACK, 1'b0, 8'h00,
                                                      YMB_END_COMMIT, YMB_STAT_RUN);
                     step_out.count = 2'd1;
                  end else begin
                     step_out.first = ymb_make_result(1'b1, YMB_NAK, 1'b0, 8'h00,
                                                      YMB_END_DISCARD, YMB_STAT_RUN);
                     step_out.count = 2'd1;
                  end
               end
            endcase
         end
      end

      if (step_out.count == 2'd1) begin
         step_out.first.last = 1'b1;
      end
      if (step_out.count == 2'd2) begin
         step_out.second.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         sub_ff        <= SS_START;
         long_block_ff <= 1'b0;
         byte_index_ff <= '0;
         crc_ff        <= '0;
         crc_high_ff   <= '0;
         eot_count_ff  <= '0;
         remaining_ff  <= '0;
         name_done_ff  <= 1'b0;
         digits_ff     <= 1'b0;
         accum_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         sub_ff        <= sub_in;
         long_block_ff <= long_block_in;
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
         crc_high_ff   <= crc_high_in;
         eot_count_ff  <= eot_count_in;
         remaining_ff  <= remaining_in;
         name_done_ff  <= name_done_in;
         digits_ff     <= digits_in;
         accum_ff      <= accum_in;
      end
   end

endmodule

// ===== sv/ymb_rsp_fifo.sv =====
// small result queue taking up to two results per cycle and giving one
module ymb_rsp_fifo
   import ymb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ymb_step_type   push,
   output logic           room,
   output logic           out_valid,
   input  logic           out_ready,
   output ymb_result_type out_item
);

   localparam int PtrBits   = $clog2(YMB_FIFO_DEPTH);
   localparam int CountBits = $clog2(YMB_FIFO_DEPTH + 1);

   ymb_result_type       mem_ff [YMB_FIFO_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 pop;
   logic [PtrBits-1:0]   wr_ptr_next;

   assign out_valid   = (count_ff != '0);
   assign out_item    = mem_ff[rd_ptr_ff];
   assign pop         = out_valid && out_ready;
   // room for a full two-result push, pops in the same cycle not counted
   assign room        = (count_ff <= CountBits'(YMB_FIFO_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrBits'(push.count);
      rd_ptr_in = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CountBits'(push.count) - CountBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/ymodem_block_receiver.sv =====
// top level of the ymodem block receiver: input register, protocol core, result queue
// flow: an accepted item waits in the input register until the queue has room, is then
//   processed by the core, and its results are written to the queue and offered on rsp_
// throughput: one item per cycle while the queue has room; the queue drains one result per
//   cycle while rsp_tready is high, so a two-result item (ack plus request or finish) needs two transfers
// reset: synchronous, active high; returns to waiting for the start, no clearing pass
module ymodem_block_receiver
   import ymb_pkg::*;
#(
   parameter int SIZE_BITS = YMB_SIZE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // input items: link bytes and timeout ticks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   input  logic        req_tuser,   // kind: 0 byte, 1 tick
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_valid, tx_byte, data_valid, data_byte,
                                    // block_end, status, zero pad
   output logic        rsp_tlast    // last result of the item
);

   logic           in_valid_ff, in_valid_in;
   logic           in_kind_ff;
   logic [7:0]     in_byte_ff;
   logic           accept;
   logic           consume;
   logic           room;
   ymb_step_type   step;
   ymb_result_type out_item;

   // the held item goes to the core only when the queue can take two results
   assign consume    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // item payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // framing, crc check, size parse and reply selection
   ymb_core #(
      .SIZE_BITS (SIZE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (consume),
      .step_kind  (in_kind_ff),
      .step_byte  (in_byte_ff),
      .step_out   (step)
   );

   // results wait here until the downstream side takes them
   ymb_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {2'b00, out_item.status, out_item.block_end, out_item.data_byte,
                       out_item.data_valid, out_item.tx_byte, out_item.tx_valid};
   assign rsp_tlast = out_item.last;

endmodule
